>>> hw/rtl/fepsc_pkg.sv
// ----------------------------------------------------------------------------
// fepsc_pkg
// Shared types and constants for the framed-error PD servo controller.
// ----------------------------------------------------------------------------
package fepsc_pkg;

	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 12;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int ERR_W    = 16;

	localparam logic [7:0] FRAME_HEAD = 8'hAA;
	localparam logic [7:0] FRAME_TAIL = 8'h55;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAN_PROP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_DERIV  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_PROP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_DERIV = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd5;

	// Command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Frame receiver position codes
	localparam logic [2:0] POS_IDLE = 3'd0;
	localparam logic [2:0] POS_TAIL = 3'd5;

	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] deriv;
	} gain_pair_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] lo;
		logic [LIMIT_W-1:0] hi;
	} pulse_limits_t;

endpackage

>>> hw/rtl/framed_error_pd_servo_controller_unit.sv
// ----------------------------------------------------------------------------
// framed_error_pd_servo_controller_unit
// Framed serial error receiver driving a two-axis PD servo loop.
// ----------------------------------------------------------------------------
// Output: a transfer's result is valid in the output register in the next cycle.
// Throughput: one item per cycle unless out_ready stalls; the output register
// frees in the same cycle it is taken; in_ready follows out_ready combinationally.
// Reset: gains and limits to defaults, pulses to center (1500), errors,
// frame position and indicator to zero; the output register empties.
// ----------------------------------------------------------------------------
module framed_error_pd_servo_controller_unit
	import fepsc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 16,
	parameter int PULSE_BITS     = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [7:0]            rx_byte,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PULSE_BITS-1:0] pan_width,
	output logic [PULSE_BITS-1:0] tilt_width,
	output logic                  frame_accepted,
	output logic                  frame_dropped,
	output logic                  indicator,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam logic [PULSE_BITS-1:0] PULSE_CENTER = PULSE_BITS'(1500);

	gain_pair_t    pan_gain_q, tilt_gain_q;
	pulse_limits_t limits_q;

	logic [2:0]              frame_pos_q;
	logic [7:0]              payload_q [4];
	logic signed [ERR_W-1:0] pan_err_q, tilt_err_q, pan_err_before_q, tilt_err_before_q;
	logic [PULSE_BITS-1:0]   pan_now_q, tilt_now_q;
	logic                    indicator_q;

	logic                    out_valid_q;
	logic [PULSE_BITS-1:0]   pan_out_q, tilt_out_q;
	logic                    accepted_q, dropped_q, indicator_out_q;

	logic                    xfer;
	logic                    is_tick, is_tail, tail_good;
	logic [PULSE_BITS-1:0]   pan_next, tilt_next;

	assign in_ready  = !out_valid_q || out_ready;
	assign xfer      = in_valid && in_ready;
	assign is_tick   = (command == CMD_TICK);
	assign is_tail   = !is_tick && (frame_pos_q == POS_TAIL);
	assign tail_good = is_tail && (rx_byte == FRAME_TAIL);

	fepsc_pd_axis #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.PULSE_BITS    (PULSE_BITS)
	) u_pan (
		.gains     (pan_gain_q),
		.limits    (limits_q),
		.subtract  (1'b1),
		.err       (pan_err_q),
		.err_before(pan_err_before_q),
		.pulse_now (pan_now_q),
		.pulse_next(pan_next)
	);

	fepsc_pd_axis #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.PULSE_BITS    (PULSE_BITS)
	) u_tilt (
		.gains     (tilt_gain_q),
		.limits    (limits_q),
		.subtract  (1'b0),
		.err       (tilt_err_q),
		.err_before(tilt_err_before_q),
		.pulse_now (tilt_now_q),
		.pulse_next(tilt_next)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_gain_q  <= '{prop: 16'd5243, deriv: 16'd1311};
			tilt_gain_q <= '{prop: 16'd5243, deriv: 16'd1311};
			limits_q    <= '{lo: 12'd500, hi: 12'd2500};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAN_PROP:   pan_gain_q.prop   <= cfg_data;
				REG_PAN_DERIV:  pan_gain_q.deriv  <= cfg_data;
				REG_TILT_PROP:  tilt_gain_q.prop  <= cfg_data;
				REG_TILT_DERIV: tilt_gain_q.deriv <= cfg_data;
				REG_FLOOR:      limits_q.lo       <= cfg_data[LIMIT_W-1:0];
				REG_CEILING:    limits_q.hi       <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// frame payload bytes, always written before the tail reads them
	always_ff @(posedge clk) begin
		if (xfer && !is_tick && frame_pos_q != POS_IDLE && frame_pos_q != POS_TAIL) begin
			payload_q[2'(frame_pos_q - 3'd1)] <= rx_byte;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q       <= POS_IDLE;
			pan_err_q         <= '0;
			tilt_err_q        <= '0;
			pan_err_before_q  <= '0;
			tilt_err_before_q <= '0;
			pan_now_q         <= PULSE_CENTER;
			tilt_now_q        <= PULSE_CENTER;
			indicator_q       <= 1'b0;
		end else if (xfer) begin
			if (is_tick) begin
				pan_now_q         <= pan_next;
				tilt_now_q        <= tilt_next;
				pan_err_before_q  <= pan_err_q;
				tilt_err_before_q <= tilt_err_q;
			end else if (frame_pos_q == POS_IDLE) begin
				if (rx_byte == FRAME_HEAD) begin
					frame_pos_q <= 3'd1;
				end
			end else if (is_tail) begin
				frame_pos_q <= POS_IDLE;
				if (tail_good) begin
					pan_err_q   <= $signed({payload_q[0], payload_q[1]});
					tilt_err_q  <= $signed({payload_q[2], payload_q[3]});
					indicator_q <= !indicator_q;
				end
			end else begin
				frame_pos_q <= frame_pos_q + 3'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			pan_out_q       <= is_tick ? pan_next : pan_now_q;
			tilt_out_q      <= is_tick ? tilt_next : tilt_now_q;
			accepted_q      <= tail_good;
			dropped_q       <= is_tail && !tail_good;
			indicator_out_q <= tail_good ? !indicator_q : indicator_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pan_width      = pan_out_q;
	assign tilt_width     = tilt_out_q;
	assign frame_accepted = accepted_q;
	assign frame_dropped  = dropped_q;
	assign indicator      = indicator_out_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pos_q <= POS_TAIL)
		else $error("frame position out of range");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(accepted_q && dropped_q))
		else $error("frame both accepted and dropped");

	a_indicator_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && tail_good) |=> (indicator_q != $past(indicator_q)))
		else $error("indicator did not toggle on good frame");

	a_tick_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && is_tick && !cfg_we && limits_q.lo <= limits_q.hi) |=>
		(pan_now_q >= PULSE_BITS'(limits_q.lo) && pan_now_q <= PULSE_BITS'(limits_q.hi)
		&& tilt_now_q >= PULSE_BITS'(limits_q.lo) && tilt_now_q <= PULSE_BITS'(limits_q.hi)))
		else $error("pulse outside limits after tick");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && is_tick) |=> (pan_out_q == pan_now_q && tilt_out_q == tilt_now_q))
		else $error("output pulse differs from servo state");

endmodule

>>> hw/rtl/fepsc_pd_axis.sv
// ----------------------------------------------------------------------------
// fepsc_pd_axis
// One servo axis: PD adjustment, truncated toward zero, applied to the
// current pulse and clamped to the pulse limits. Purely combinational.
// ----------------------------------------------------------------------------
module fepsc_pd_axis
	import fepsc_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 16,
	parameter int PULSE_BITS     = 12
) (
	input  gain_pair_t                gains,
	input  pulse_limits_t             limits,
	input  logic                      subtract,
	input  logic signed [ERR_W-1:0]   err,
	input  logic signed [ERR_W-1:0]   err_before,
	input  logic [PULSE_BITS-1:0]     pulse_now,
	output logic [PULSE_BITS-1:0]     pulse_next
);

	localparam int DIFF_W = ERR_W + 1;
	localparam int PP_W   = GAIN_W + 1 + ERR_W;
	localparam int PD_W   = GAIN_W + 1 + DIFF_W;
	localparam int SUM_W  = PD_W + 1;
	localparam int NW     = SUM_W + 1;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PP_W-1:0]   prod_p;
	logic signed [PD_W-1:0]   prod_d;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  biased;
	logic signed [SUM_W-1:0]  adj;
	logic signed [NW-1:0]     adj_x;
	logic signed [NW-1:0]     pulse_x;
	logic signed [NW-1:0]     lo_x;
	logic signed [NW-1:0]     hi_x;
	logic signed [NW-1:0]     moved;

	assign diff   = DIFF_W'(err) - DIFF_W'(err_before);
	assign prod_p = $signed({1'b0, gains.prop}) * err;
	assign prod_d = $signed({1'b0, gains.deriv}) * diff;
	assign sum    = SUM_W'(prod_p) + SUM_W'(prod_d);

	// bias negative sums so the arithmetic shift truncates toward zero
	assign biased = sum[SUM_W-1] ? sum + SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1) : sum;
	assign adj    = biased >>> GAIN_FRAC_BITS;
	assign adj_x  = NW'(adj);

	assign pulse_x = $signed(NW'(pulse_now));
	assign lo_x    = $signed(NW'(limits.lo));
	assign hi_x    = $signed(NW'(limits.hi));
	assign moved   = subtract ? pulse_x - adj_x : pulse_x + adj_x;

	always_comb begin
		if (moved < lo_x) begin
			pulse_next = PULSE_BITS'(limits.lo);
		end else if (moved > hi_x) begin
			pulse_next = PULSE_BITS'(limits.hi);
		end else begin
			pulse_next = moved[PULSE_BITS-1:0];
		end
	end

endmodule

>>> tb/sv/servo_result_checker.sv
// ----------------------------------------------------------------------------
// servo_result_checker
// Watches the byte/tick and pulse channels of the PD servo controller, keeps
// its own frame receiver and PD loop, and compares every result transfer.
// ----------------------------------------------------------------------------
module servo_result_checker
	import fepsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 command,
	input  logic [7:0]           rx_byte,

	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [LIMIT_W-1:0]   pan_width,
	input  logic [LIMIT_W-1:0]   tilt_width,
	input  logic                 frame_accepted,
	input  logic                 frame_dropped,
	input  logic                 indicator,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	output int                   mismatch_count,
	output int                   results_awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 16;
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd5243;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd1311;
	localparam logic [LIMIT_W-1:0] FLOOR_RST = 12'd500;
	localparam logic [LIMIT_W-1:0] CEILING_RST = 12'd2500;
	localparam logic [LIMIT_W-1:0] PULSE_CENTER = 12'd1500;

	typedef struct packed {
		logic [LIMIT_W-1:0] pan;
		logic [LIMIT_W-1:0] tilt;
		logic               accepted;
		logic               dropped;
		logic               lamp;
	} servo_result_t;

	servo_result_t awaited_results[$];

	gain_pair_t              pan_gains, tilt_gains;
	pulse_limits_t           pulse_bounds;
	logic [2:0]              frame_pos;
	logic [7:0]              frame_bytes [0:3];
	logic signed [ERR_W-1:0] pan_err, tilt_err, pan_err_prev, tilt_err_prev;
	logic [LIMIT_W-1:0]      pan_now, tilt_now;
	logic                    lamp;

	// exact PD sum, truncated toward zero
	function automatic longint pd_adjustment(gain_pair_t g, logic signed [ERR_W-1:0] err,
			logic signed [ERR_W-1:0] err_prev);
		longint e;
		longint d;
		longint sum;
		e = longint'(err);
		d = e - longint'(err_prev);
		sum = longint'(g.prop) * e + longint'(g.deriv) * d;
		if (sum < 0)
			return -((-sum) >> FRAC_BITS);
		return sum >> FRAC_BITS;
	endfunction

	// floor checked first: with crossed limits, below floor gives floor, else ceiling
	function automatic logic [LIMIT_W-1:0] clamp_pulse_width(longint p, pulse_limits_t lim);
		if (p < longint'(lim.lo))
			return lim.lo;
		if (p > longint'(lim.hi))
			return lim.hi;
		return LIMIT_W'(p);
	endfunction

	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		servo_result_t want;
		servo_result_t fresh;
		if (!arst_n) begin
			pan_gains = '{prop: PROP_GAIN_RST, deriv: DERIV_GAIN_RST};
			tilt_gains = '{prop: PROP_GAIN_RST, deriv: DERIV_GAIN_RST};
			pulse_bounds = '{lo: FLOOR_RST, hi: CEILING_RST};
			frame_pos = POS_IDLE;
			for (int i = 0; i < 4; i++)
				frame_bytes[i] = '0;
			pan_err = '0;
			tilt_err = '0;
			pan_err_prev = '0;
			tilt_err_prev = '0;
			pan_now = PULSE_CENTER;
			tilt_now = PULSE_CENTER;
			lamp = 1'b0;
			awaited_results.delete();
		end else begin
			// a result is registered before it leaves, so compare before queuing
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no result awaited");
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("pan_width", want.pan, pan_width);
					compare_field("tilt_width", want.tilt, tilt_width);
					compare_field("frame_accepted", want.accepted, frame_accepted);
					compare_field("frame_dropped", want.dropped, frame_dropped);
					compare_field("indicator", want.lamp, indicator);
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_PAN_PROP:   pan_gains.prop = cfg_data;
					REG_PAN_DERIV:  pan_gains.deriv = cfg_data;
					REG_TILT_PROP:  tilt_gains.prop = cfg_data;
					REG_TILT_DERIV: tilt_gains.deriv = cfg_data;
					REG_FLOOR:      pulse_bounds.lo = cfg_data[LIMIT_W-1:0];
					REG_CEILING:    pulse_bounds.hi = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				fresh.accepted = 1'b0;
				fresh.dropped = 1'b0;
				if (command == CMD_BYTE) begin
					if (frame_pos == POS_IDLE) begin
						if (rx_byte == FRAME_HEAD)
							frame_pos = 3'd1;
					end else if (frame_pos != POS_TAIL) begin
						frame_bytes[frame_pos - 1] = rx_byte;
						frame_pos = frame_pos + 3'd1;
					end else begin
						if (rx_byte == FRAME_TAIL) begin
							pan_err = {frame_bytes[0], frame_bytes[1]};
							tilt_err = {frame_bytes[2], frame_bytes[3]};
							lamp = ~lamp;
							fresh.accepted = 1'b1;
						end else begin
							fresh.dropped = 1'b1;
						end
						frame_pos = POS_IDLE;
					end
				end else begin
					pan_now = clamp_pulse_width(longint'(pan_now)
						- pd_adjustment(pan_gains, pan_err, pan_err_prev), pulse_bounds);
					tilt_now = clamp_pulse_width(longint'(tilt_now)
						+ pd_adjustment(tilt_gains, tilt_err, tilt_err_prev), pulse_bounds);
					pan_err_prev = pan_err;
					tilt_err_prev = tilt_err;
				end
				fresh.pan = pan_now;
				fresh.tilt = tilt_now;
				fresh.lamp = lamp;
				awaited_results.push_back(fresh);
			end
		end
		results_awaited = awaited_results.size();
	end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives framed error bytes, control ticks and register writes into the PD
// servo controller under varying back-pressure; the checker grades results.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fepsc_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 command = CMD_BYTE;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [LIMIT_W-1:0]   pan_width, tilt_width;
	logic                 frame_accepted, frame_dropped, indicator;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PAN_PROP;
	logic [CFG_W-1:0]     cfg_data = '0;

	int   mismatch_count;
	int   results_awaited;
	int   tx_gap_pct = 0;
	int   rx_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int   hold_left = 0;

	framed_error_pd_servo_controller_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pan_width      (pan_width),
		.tilt_width     (tilt_width),
		.frame_accepted (frame_accepted),
		.frame_dropped  (frame_dropped),
		.indicator      (indicator),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	servo_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pan_width       (pan_width),
		.tilt_width      (tilt_width),
		.frame_accepted  (frame_accepted),
		.frame_dropped   (frame_dropped),
		.indicator       (indicator),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_awaited (results_awaited)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			out_ready <= 1'b0;
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// called and returns just after a falling edge
	task automatic send_item(input logic cmd, input logic [7:0] b);
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] x_err, input logic [15:0] y_err,
			input logic [7:0] tail);
		send_item(CMD_BYTE, FRAME_HEAD);
		send_item(CMD_BYTE, x_err[15:8]);
		send_item(CMD_BYTE, x_err[7:0]);
		send_item(CMD_BYTE, y_err[15:8]);
		send_item(CMD_BYTE, y_err[7:0]);
		send_item(CMD_BYTE, tail);
	endtask

	// waits for the block to drain, then writes every register
	task automatic load_settings(input logic [CFG_W-1:0] pan_p, input logic [CFG_W-1:0] pan_d,
			input logic [CFG_W-1:0] tilt_p, input logic [CFG_W-1:0] tilt_d,
			input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		logic [CFG_IDX_W-1:0] regs [0:5];
		logic [CFG_W-1:0]     vals [0:5];
		regs = '{REG_PAN_PROP, REG_PAN_DERIV, REG_TILT_PROP, REG_TILT_DERIV,
			REG_FLOOR, REG_CEILING};
		vals = '{pan_p, pan_d, tilt_p, tilt_d, lo, hi};
		in_valid <= 1'b0;
		while (results_awaited != 0)
			@(negedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_error();
		case ($urandom_range(4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly clean frames and ticks; some bad trailers, stray and cut-off bytes
	task automatic random_traffic(input int count);
		int done;
		int pick;
		int n;
		logic [7:0] tail;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_frame(pick_error(), pick_error(), FRAME_TAIL);
				done += 6;
			end else if (pick < 55) begin
				tail = 8'($urandom);
				if (tail == FRAME_TAIL)
					tail = ~tail;
				send_frame(16'($urandom), 16'($urandom), tail);
				done += 6;
			end else if (pick < 65) begin
				if ($urandom_range(1)) begin
					send_item(CMD_BYTE, FRAME_HEAD);
					done += 1;
				end
				n = $urandom_range(1, 4);
				repeat (n)
					send_item(CMD_BYTE, 8'($urandom));
				done += n;
			end else begin
				n = $urandom_range(1, 3);
				repeat (n)
					send_item(CMD_TICK, 8'($urandom));
				done += n;
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset state, idle noise, error extremes, bad trailer,
		// head byte inside the payload
		send_item(CMD_TICK, 8'hFF);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, FRAME_TAIL);
		send_frame(16'h7FFF, 16'h8000, FRAME_TAIL);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h5A);
		send_frame(16'h8000, 16'h7FFF, 8'h00);
		send_frame({FRAME_HEAD, FRAME_HEAD}, {FRAME_HEAD, FRAME_HEAD}, FRAME_TAIL);
		send_item(CMD_TICK, 8'hA5);

		tx_gap_pct = 8;
		rx_stall_pct <= 80;
		load_settings(16'd5243, 16'd1311, 16'd5243, 16'd1311, 16'd500, 16'd2500);
		random_traffic(300);
		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd4095);
		random_traffic(200);

		tx_gap_pct = 80;
		rx_stall_pct <= 8;
		// floor above ceiling
		load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(2048, 4095)), 16'($urandom_range(0, 2047)));
		random_traffic(150);
		load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(0, 2047)), 16'($urandom_range(2048, 4095)));
		random_traffic(300);

		tx_gap_pct = 0;
		rx_stall_pct <= 0;
		load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1000, 16'd2000);
		hold_req <= ~hold_req;
		random_traffic(300);

		in_valid <= 1'b0;
		while (results_awaited != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> framed_error_pd_servo_controller_unit.f
hw/rtl/fepsc_pkg.sv
hw/rtl/fepsc_pd_axis.sv
hw/rtl/framed_error_pd_servo_controller_unit.sv
tb/sv/servo_result_checker.sv
tb/sv/tb_top.sv
